// ===== rtl/core/srsc_pkg.sv =====
// Shared constants and types for the sorted record search and count unit.
// Depends on nothing; every other file of the block refers to it by scoped names.
package srsc_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int ID_W    = 63;
  localparam int TALLY_W = 31;
  localparam int PROBE_W = 64;
  localparam int OP_W    = 2;
  localparam int KEY_W   = 2;

  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_COUNT  = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

  localparam logic [KEY_W-1:0] KEY_ID        = 2'd0;
  localparam logic [KEY_W-1:0] KEY_RETWEETS  = 2'd1;
  localparam logic [KEY_W-1:0] KEY_FAVORITES = 2'd2;
  localparam logic [KEY_W-1:0] KEY_INVALID   = 2'd3;

  typedef logic [OP_W-1:0]           op_t;
  typedef logic [KEY_W-1:0]          key_t;
  typedef logic [ID_W-1:0]           id_t;
  typedef logic [TALLY_W-1:0]        tally_t;
  typedef logic signed [PROBE_W-1:0] probe_t;
  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic [CNT_W-1:0]          cnt_t;

  // One stored table entry.
  typedef struct packed {
    id_t    id;
    tally_t retweets;
    tally_t favorites;
  } rec_t;

endpackage

// ===== rtl/core/srsc_if.sv =====
// Valid/ready channel interfaces for the input and result words of the unit.
// Depends on srsc_pkg for the payload types.
interface srsc_in_if;
  logic                     valid;
  logic                     ready;
  srsc_pkg::op_t            operation;
  srsc_pkg::id_t            record_id;
  srsc_pkg::tally_t         record_retweets;
  srsc_pkg::tally_t         record_favorites;
  srsc_pkg::probe_t         probe_value;

  modport source (output valid, output operation, output record_id,
                  output record_retweets, output record_favorites,
                  output probe_value, input ready);
  modport sink   (input valid, input operation, input record_id,
                  input record_retweets, input record_favorites,
                  input probe_value, output ready);
endinterface

interface srsc_out_if;
  logic                     valid;
  logic                     ready;
  logic                     found;
  srsc_pkg::idx_t           hit_index;
  srsc_pkg::cnt_t           above_count;
  logic                     table_full;

  modport source (output valid, output found, output hit_index,
                  output above_count, output table_full, input ready);
  modport sink   (input valid, input found, input hit_index,
                  input above_count, input table_full, output ready);
endinterface

// ===== rtl/core/sorted_record_search_and_count_unit.sv =====
// Sorted record table with midpoint binary search and threshold count.
// Depends on srsc_pkg and the channel interfaces in srsc_if.sv.

// The unit holds up to srsc_pkg::TABLE_DEPTH records in one synchronous
// memory, written at the fill count and read through a registered port,
// and works on one input word at a time. An append or a clear goes straight
// to the result state once accepted. Each search probe of the memory reads
// the midpoint entry, then compares and narrows the range. A count streams
// the filled entries through the read port one per cycle. Each result word
// sits in an output register, and the next input word is taken as soon as
// the work is finished, even while that result waits for the downstream
// side; a second finished result holds the unit until that register frees.
// The key_field register must only be written while the unit is idle; a
// value of three makes searches and counts return zero. The memory holds no
// reset: a clear only zeroes the fill count, and only entries below the fill
// count ever reach a result.
module sorted_record_search_and_count_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  srsc_in_if.sink              in_chan,
  srsc_out_if.source           out_chan,
  input  logic                 cfg_we,
  input  srsc_pkg::key_t       cfg_wdata
);

  localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for an input word
  localparam logic [2:0] ST_SRD  = 3'd1;  // search: read the midpoint entry
  localparam logic [2:0] ST_SCMP = 3'd2;  // search: compare and narrow
  localparam logic [2:0] ST_CNT  = 3'd3;  // count: stream entries
  localparam logic [2:0] ST_DONE = 3'd4;  // hand the result to the output

  // Record memory, written on append and read through a registered port.
  srsc_pkg::rec_t mem [srsc_pkg::TABLE_DEPTH];
  srsc_pkg::rec_t rd_data_r;
  srsc_pkg::idx_t rd_addr;

  logic [2:0]       state_r, state_nxt;
  srsc_pkg::key_t   key_field_r;
  srsc_pkg::cnt_t   fill_r, fill_nxt;
  srsc_pkg::probe_t probe_r, probe_nxt;

  // Search window kept as [lo, hi) so that both ends stay unsigned.
  srsc_pkg::cnt_t   lo_r, lo_nxt;
  srsc_pkg::cnt_t   hi_r, hi_nxt;
  srsc_pkg::idx_t   mid_r, mid_nxt;
  srsc_pkg::cnt_t   mid_full;

  srsc_pkg::cnt_t   scan_r, scan_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  srsc_pkg::cnt_t   above_r, above_nxt;

  // Pending result, moved to the output register in ST_DONE.
  logic             res_found_r, res_found_nxt;
  srsc_pkg::idx_t   res_hit_r, res_hit_nxt;
  srsc_pkg::cnt_t   res_above_r, res_above_nxt;
  logic             res_full_r, res_full_nxt;

  logic             out_valid_r;
  logic             out_found_r;
  srsc_pkg::idx_t   out_hit_r;
  srsc_pkg::cnt_t   out_above_r;
  logic             out_full_r;

  logic             in_fire;
  logic             out_free;
  logic             mem_we;
  logic [srsc_pkg::PROBE_W-1:0] sel_field;
  logic             field_gt;
  logic             field_eq;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;

  assign in_chan.ready        = (state_r == ST_IDLE);
  assign out_chan.valid       = out_valid_r;
  assign out_chan.found       = out_found_r;
  assign out_chan.hit_index   = out_hit_r;
  assign out_chan.above_count = out_above_r;
  assign out_chan.table_full  = out_full_r;

  // Midpoint of a non-empty window: lo + (hi - lo - 1) / 2.
  assign mid_full = lo_r + ((hi_r - lo_r - srsc_pkg::CNT_W'(1)) >> 1);

  assign rd_addr = (state_r == ST_CNT) ? scan_r[srsc_pkg::IDX_W-1:0]
                                       : mid_full[srsc_pkg::IDX_W-1:0];

  assign mem_we = in_fire && (in_chan.operation == srsc_pkg::OP_APPEND) &&
                  (fill_r != srsc_pkg::CNT_W'(srsc_pkg::TABLE_DEPTH));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[fill_r[srsc_pkg::IDX_W-1:0]] <= '{id:        in_chan.record_id,
                                            retweets:  in_chan.record_retweets,
                                            favorites: in_chan.record_favorites};
    end
    rd_data_r <= mem[rd_addr];
  end

  // The selected field is unsigned; a negative probe lies below every entry.
  always_comb begin
    case (key_field_r)
      srsc_pkg::KEY_ID:        sel_field = srsc_pkg::PROBE_W'(rd_data_r.id);
      srsc_pkg::KEY_RETWEETS:  sel_field = srsc_pkg::PROBE_W'(rd_data_r.retweets);
      srsc_pkg::KEY_FAVORITES: sel_field = srsc_pkg::PROBE_W'(rd_data_r.favorites);
      default:                 sel_field = '0;
    endcase
  end

  assign field_eq = !probe_r[srsc_pkg::PROBE_W-1] &&
                    (sel_field == $unsigned(probe_r));
  assign field_gt = probe_r[srsc_pkg::PROBE_W-1] ||
                    (sel_field > $unsigned(probe_r));

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    probe_nxt     = probe_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    scan_nxt      = scan_r;
    rd_vld_nxt    = 1'b0;
    above_nxt     = above_r;
    res_found_nxt = res_found_r;
    res_hit_nxt   = res_hit_r;
    res_above_nxt = res_above_r;
    res_full_nxt  = res_full_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          probe_nxt     = in_chan.probe_value;
          res_found_nxt = 1'b0;
          res_hit_nxt   = '0;
          res_above_nxt = '0;
          res_full_nxt  = 1'b0;
          lo_nxt        = '0;
          hi_nxt        = fill_r;
          scan_nxt      = '0;
          above_nxt     = '0;
          state_nxt     = ST_DONE;
          unique case (in_chan.operation)
            srsc_pkg::OP_APPEND: begin
              if (fill_r == srsc_pkg::CNT_W'(srsc_pkg::TABLE_DEPTH)) begin
                res_full_nxt = 1'b1;
              end else begin
                fill_nxt = fill_r + srsc_pkg::CNT_W'(1);
              end
            end
            srsc_pkg::OP_SEARCH: begin
              if (key_field_r != srsc_pkg::KEY_INVALID &&
                  fill_r != '0) begin
                state_nxt = ST_SRD;
              end
            end
            srsc_pkg::OP_COUNT: begin
              if (key_field_r != srsc_pkg::KEY_INVALID) begin
                state_nxt = ST_CNT;
              end
            end
            srsc_pkg::OP_CLEAR: begin
              fill_nxt = '0;
            end
            default: ;
          endcase
        end
      end

      ST_SRD: begin
        mid_nxt   = mid_full[srsc_pkg::IDX_W-1:0];
        state_nxt = ST_SCMP;
      end

      ST_SCMP: begin
        if (field_eq) begin
          res_found_nxt = 1'b1;
          res_hit_nxt   = mid_r;
          state_nxt     = ST_DONE;
        end else begin
          if (field_gt) begin
            hi_nxt = srsc_pkg::CNT_W'(mid_r);
          end else begin
            lo_nxt = srsc_pkg::CNT_W'(mid_r) + srsc_pkg::CNT_W'(1);
          end
          state_nxt = (lo_nxt < hi_nxt) ? ST_SRD : ST_DONE;
        end
      end

      ST_CNT: begin
        // Issue one read per cycle; the compare follows in the next cycle, once the read data is registered.
        if (scan_r != fill_r) begin
          scan_nxt   = scan_r + srsc_pkg::CNT_W'(1);
          rd_vld_nxt = 1'b1;
        end
        if (rd_vld_r && field_gt) begin
          above_nxt = above_r + srsc_pkg::CNT_W'(1);
        end
        if (scan_r == fill_r && !rd_vld_r) begin
          res_above_nxt = above_r;
          state_nxt     = ST_DONE;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      key_field_r <= srsc_pkg::KEY_ID;
      fill_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      rd_vld_r <= rd_vld_nxt;
      if (cfg_we) begin
        key_field_r <= cfg_wdata;
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    probe_r     <= probe_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    scan_r      <= scan_nxt;
    above_r     <= above_nxt;
    res_found_r <= res_found_nxt;
    res_hit_r   <= res_hit_nxt;
    res_above_r <= res_above_nxt;
    res_full_r  <= res_full_nxt;
    if (state_r == ST_DONE && out_free) begin
      out_found_r <= res_found_r;
      out_hit_r   <= res_hit_r;
      out_above_r <= res_above_r;
      out_full_r  <= res_full_r;
    end
  end

endmodule
